// ===== src/lnorm_pkg.sv =====
// ----------------------------------------------------------------------------
// lnorm_pkg
// Shared widths, controller states and the command/status bundles that join
// the layer normalization controller to its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lnorm_pkg;

   // Row buffer geometry
   localparam int MAX_ROW = 64;
   localparam int ADDR_W  = $clog2(MAX_ROW);
   localparam int LEN_W   = 7;

   // Field widths
   localparam int DATA_W  = 16;
   localparam int EPS_W   = 16;
   localparam int ENTRY_W = 3 * DATA_W;

   // Statistics widths
   localparam int SUM_W   = 22;             // running sum of samples
   localparam int DEV_W   = 24;             // n*x - sum, signed
   localparam int MAG_W   = 23;             // |n*x - sum|
   localparam int SQ_W    = 2 * MAG_W;      // deviation squared
   localparam int N2_W    = 13;
   localparam int N3_W    = 19;
   localparam int W_W     = 52;             // variance sum plus epsilon*n^3
   localparam int Q_SH    = 34;             // n^3 scaled before the divide
   localparam int DIVD_W  = N3_W + Q_SH;    // divider dividend and quotient
   localparam int DIVC_W  = $clog2(DIVD_W + 1);
   localparam int ROOT_W  = (DIVD_W + 1) / 2;
   localparam int RSTD_W  = 26;

   // Output product widths
   localparam int P1_W    = MAG_W + RSTD_W;
   localparam int PLO_W   = 25;
   localparam int PHI_W   = P1_W - PLO_W;
   localparam int PL_W    = PLO_W + DATA_W;
   localparam int PH_W    = PHI_W + DATA_W;
   localparam int PROD_W  = P1_W + DATA_W;
   localparam int RND_SH  = 28;
   localparam int TQ_W    = PROD_W - RND_SH;
   localparam int Y_W     = TQ_W + 2;
   localparam int OUT_MAX = 32767;
   localparam int OUT_MIN = -32768;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_ROW_LENGTH = 1'b0;
   localparam logic [0:0] REG_EPSILON    = 1'b1;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_N2,
      ST_N3,
      ST_EPS,
      ST_V_RD,
      ST_V_NX,
      ST_V_DEV,
      ST_V_SQ,
      ST_V_ACC,
      ST_Q_START,
      ST_Q_WAIT,
      ST_R_START,
      ST_R_WAIT,
      ST_RSTD,
      ST_O_RD,
      ST_O_NX,
      ST_O_DEV,
      ST_O_M1,
      ST_O_M2,
      ST_O_T,
      ST_D_START,
      ST_D_WAIT,
      ST_O_OUT,
      ST_O_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic n2_en;
      logic n3_en;
      logic eps_en;
      logic idx_clr;
      logic idx_inc;
      logic rd_en;
      logic nx_en;
      logic dev_en;
      logic sq_en;
      logic acc_en;
      logic q_start;
      logic r_start;
      logic rstd_en;
      logic m1_en;
      logic m2_en;
      logic t_en;
      logic d_start;
      logic out_load;
      logic row_clr;
   } cmd_type;

   typedef struct packed {
      logic row_full;
      logic idx_last;
      logic w_zero;
      logic div_done;
      logic sqrt_done;
      logic out_taken;
   } status_type;

endpackage

`default_nettype wire

// ===== src/lnorm_div.sv =====
// ----------------------------------------------------------------------------
// lnorm_div
// Restoring divider, one quotient bit per cycle, shared by the root scale
// and by the per-element rounding divide.
// ----------------------------------------------------------------------------
`default_nettype none

module lnorm_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [lnorm_pkg::DIVD_W-1:0] dividend,
   input  wire logic [lnorm_pkg::W_W-1:0]  divisor,
   output logic      [lnorm_pkg::DIVD_W-1:0] quotient,
   output logic                            busy,
   output logic                            done
);
   import lnorm_pkg::*;

   logic [W_W-1:0]    rem_ff, rem_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [W_W-1:0]    dvs_ff, dvs_in;
   logic [DIVC_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [W_W:0]      trial;
   logic              fits;

   // Shift in the next dividend bit and try the subtract
   always_comb begin
      trial = {rem_ff, quo_ff[DIVD_W-1]};
      fits  = trial >= {1'b0, dvs_ff};
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = DIVC_W'(DIVD_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = fits ? W_W'(trial - {1'b0, dvs_ff}) : W_W'(trial);
         quo_in = {quo_ff[DIVD_W-2:0], fits};
         cnt_in = cnt_ff - DIVC_W'(1);
         if (cnt_ff == DIVC_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign quotient = quo_ff;
   assign busy     = busy_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

// ===== src/lnorm_sqrt.sv =====
// ----------------------------------------------------------------------------
// lnorm_sqrt
// Integer square root, one result bit per cycle (digit recurrence).
// ----------------------------------------------------------------------------
`default_nettype none

module lnorm_sqrt (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [lnorm_pkg::DIVD_W-1:0] radicand,
   output logic      [lnorm_pkg::ROOT_W-1:0] root,
   output logic                              done
);
   import lnorm_pkg::*;

   localparam int TOP_BIT = (DIVD_W - 1) - ((DIVD_W - 1) % 2);

   logic [DIVD_W-1:0] v_ff, v_in;
   logic [DIVD_W:0]   res_ff, res_in;
   logic [DIVD_W-1:0] bit_ff, bit_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIVD_W:0]   trial;

   always_comb begin
      trial   = res_ff + {1'b0, bit_ff};
      v_in    = v_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         v_in    = radicand;
         res_in  = '0;
         bit_in  = DIVD_W'(1) << TOP_BIT;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         // Take the digit when the remainder covers the trial value
         if ({1'b0, v_ff} >= trial) begin
            v_in   = DIVD_W'({1'b0, v_ff} - trial);
            res_in = (res_ff >> 1) + {1'b0, bit_ff};
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == DIVD_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign root = res_ff[ROOT_W-1:0];
   assign done = done_ff;

endmodule

`default_nettype wire

// ===== src/lnorm_dp.sv =====
// ----------------------------------------------------------------------------
// lnorm_dp
// Datapath: row buffer, running sum, variance accumulator, root scale, the
// per-element output arithmetic and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lnorm_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire lnorm_pkg::cmd_type                cmd,
   output lnorm_pkg::status_type                  status,
   input  wire logic [lnorm_pkg::LEN_W-1:0]       eff_len,
   input  wire logic [lnorm_pkg::EPS_W-1:0]       epsilon,
   input  wire logic signed [lnorm_pkg::DATA_W-1:0] req_sample,
   input  wire logic signed [lnorm_pkg::DATA_W-1:0] req_gain,
   input  wire logic signed [lnorm_pkg::DATA_W-1:0] req_offset,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_valid,
   output logic signed [lnorm_pkg::DATA_W-1:0]    rsp_normalized,
   output logic                                   rsp_last_of_row
);
   import lnorm_pkg::*;

   // Row buffer
   logic [ENTRY_W-1:0] mem_ff [MAX_ROW];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic signed [DATA_W-1:0] rd_sample, rd_gain, rd_offset;

   logic [LEN_W-1:0]        fill_ff, fill_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [ADDR_W-1:0]       idx_ff, idx_in;

   logic [N2_W-1:0]  n2_ff;
   logic [N3_W-1:0]  n3_ff;
   logic signed [DEV_W-1:0] nx_ff, dev;
   logic             dev_neg_ff;
   logic [MAG_W-1:0] dm_ff;
   logic [SQ_W-1:0]  sq_ff;
   logic [W_W-1:0]   acc_ff, acc_in;
   logic [RSTD_W-1:0] rstd_ff;
   logic [ROOT_W:0]  root_inc;
   logic [P1_W-1:0]  p1_ff;
   logic [DATA_W-1:0] gm;
   logic             gain_neg, out_neg_ff;
   logic [PL_W-1:0]  pl_ff;
   logic [PH_W-1:0]  ph_ff;
   logic [PROD_W-1:0] tsum;
   logic [TQ_W-1:0]  tq_ff;

   logic              div_start, div_busy, div_done;
   logic [DIVD_W-1:0] div_dividend, quotient;
   logic [W_W-1:0]    div_divisor;
   logic [ROOT_W-1:0] root;
   logic              sqrt_done;

   logic signed [Y_W-1:0] mag_s, y;
   logic signed [DATA_W-1:0] y_sat;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] norm_ff;
   logic              last_ff;
   logic              out_taken;

   assign rd_sample = rd_data_ff[3*DATA_W-1:2*DATA_W];
   assign rd_gain   = rd_data_ff[2*DATA_W-1:DATA_W];
   assign rd_offset = rd_data_ff[DATA_W-1:0];

   // Write the buffer on load, read it at the element index
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mem_ff[fill_ff[ADDR_W-1:0]] <= {req_sample, req_gain, req_offset};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[idx_ff];
      end
   end

   // Fill count and running sum
   always_comb begin
      fill_in = fill_ff;
      sum_in  = sum_ff;
      if (cmd.row_clr) begin
         fill_in = '0;
         sum_in  = '0;
      end else if (cmd.load) begin
         fill_in = fill_ff + LEN_W'(1);
         sum_in  = sum_ff + SUM_W'(req_sample);
      end
   end

   // Element index
   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         sum_ff  <= '0;
         idx_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
         idx_ff  <= idx_in;
      end
   end

   // Deviation of the current element
   assign dev = nx_ff - DEV_W'(sum_ff);

   // Variance accumulator, seeded with epsilon * n^3
   always_comb begin
      acc_in = acc_ff;
      if (cmd.eps_en) begin
         acc_in = W_W'(epsilon) * W_W'(n3_ff);
      end else if (cmd.acc_en) begin
         acc_in = acc_ff + W_W'(sq_ff);
      end
   end

   assign root_inc = {1'b0, root} + (ROOT_W + 1)'(1);
   assign gain_neg = rd_gain[DATA_W-1];
   assign gm       = gain_neg ? DATA_W'(-rd_gain) : DATA_W'(rd_gain);

   // Product plus half of n * 2^28, before the divide by n
   assign tsum = (PROD_W'(ph_ff) << PLO_W) + PROD_W'(pl_ff)
               + (PROD_W'(fill_ff) << (RND_SH - 1));

   always_ff @(posedge clock) begin
      if (cmd.n2_en) begin
         n2_ff <= N2_W'(fill_ff) * N2_W'(fill_ff);
      end
      if (cmd.n3_en) begin
         n3_ff <= N3_W'(n2_ff) * N3_W'(fill_ff);
      end
      if (cmd.nx_en) begin
         nx_ff <= DEV_W'($signed({1'b0, fill_ff})) * DEV_W'(rd_sample);
      end
      if (cmd.dev_en) begin
         dev_neg_ff <= dev[DEV_W-1];
         dm_ff      <= dev[DEV_W-1] ? MAG_W'(-dev) : MAG_W'(dev);
      end
      if (cmd.sq_en) begin
         sq_ff <= SQ_W'(dm_ff) * SQ_W'(dm_ff);
      end
      acc_ff <= acc_in;
      if (cmd.rstd_en) begin
         rstd_ff <= status.w_zero ? '0 : root_inc[RSTD_W:1];
      end
      if (cmd.m1_en) begin
         p1_ff <= P1_W'(dm_ff) * P1_W'(rstd_ff);
      end
      if (cmd.m2_en) begin
         pl_ff      <= PL_W'(p1_ff[PLO_W-1:0]) * PL_W'(gm);
         ph_ff      <= PH_W'(p1_ff[P1_W-1:PLO_W]) * PH_W'(gm);
         out_neg_ff <= dev_neg_ff ^ gain_neg;
      end
      if (cmd.t_en) begin
         tq_ff <= tsum[PROD_W-1:RND_SH];
      end
   end

   // Shared divider: n^3 * 2^34 / W for the root, then rounding divide by n
   assign div_start    = cmd.q_start | cmd.d_start;
   assign div_dividend = cmd.d_start ? DIVD_W'(tq_ff) : (DIVD_W'(n3_ff) << Q_SH);
   assign div_divisor  = cmd.d_start ? W_W'(fill_ff) : acc_ff;

   lnorm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (quotient),
      .busy     (div_busy),
      .done     (div_done)
   );

   lnorm_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.r_start),
      .radicand (quotient),
      .root     (root),
      .done     (sqrt_done)
   );

   // Apply sign, add offset, saturate
   always_comb begin
      mag_s = Y_W'(quotient[TQ_W-1:0]);
      y     = Y_W'(rd_offset) + (out_neg_ff ? -mag_s : mag_s);
      if (y > Y_W'(OUT_MAX)) begin
         y_sat = DATA_W'(OUT_MAX);
      end else if (y < Y_W'(OUT_MIN)) begin
         y_sat = DATA_W'(OUT_MIN);
      end else begin
         y_sat = y[DATA_W-1:0];
      end
   end

   // Output register: hold until taken
   assign out_taken = rsp_valid_ff & ~rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (out_taken) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         norm_ff <= y_sat;
         last_ff <= status.idx_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_normalized  = norm_ff;
   assign rsp_last_of_row = last_ff;

   // Status back to the controller
   always_comb begin
      status.row_full  = (fill_ff + LEN_W'(1)) >= eff_len;
      status.idx_last  = (LEN_W'(idx_ff) + LEN_W'(1)) == fill_ff;
      status.w_zero    = acc_ff == '0;
      status.div_done  = div_done;
      status.sqrt_done = sqrt_done;
      status.out_taken = out_taken;
   end

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LEN_W'(MAX_ROW))
      else $error("fill count beyond row buffer depth");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !rsp_valid_ff)
      else $error("item loaded while a result is pending");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_valid_ff)
      else $error("result overwritten before it was taken");
`endif

endmodule

`default_nettype wire

// ===== src/lnorm_ctrl.sv =====
// ----------------------------------------------------------------------------
// lnorm_ctrl
// Sequencer: load pass, statistics pass, root, then one output per element.
// ----------------------------------------------------------------------------
`default_nettype none

module lnorm_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire lnorm_pkg::status_type status,
   output lnorm_pkg::cmd_type         cmd
);
   import lnorm_pkg::*;

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid && status.row_full) begin
               state_in = ST_N2;
            end
         end
         ST_N2:      state_in = ST_N3;
         ST_N3:      state_in = ST_EPS;
         ST_EPS:     state_in = ST_V_RD;
         ST_V_RD:    state_in = ST_V_NX;
         ST_V_NX:    state_in = ST_V_DEV;
         ST_V_DEV:   state_in = ST_V_SQ;
         ST_V_SQ:    state_in = ST_V_ACC;
         ST_V_ACC:   state_in = status.idx_last ? ST_Q_START : ST_V_RD;
         ST_Q_START: state_in = status.w_zero ? ST_RSTD : ST_Q_WAIT;
         ST_Q_WAIT: begin
            if (status.div_done) begin
               state_in = ST_R_START;
            end
         end
         ST_R_START: state_in = ST_R_WAIT;
         ST_R_WAIT: begin
            if (status.sqrt_done) begin
               state_in = ST_RSTD;
            end
         end
         ST_RSTD:    state_in = ST_O_RD;
         ST_O_RD:    state_in = ST_O_NX;
         ST_O_NX:    state_in = ST_O_DEV;
         ST_O_DEV:   state_in = ST_O_M1;
         ST_O_M1:    state_in = ST_O_M2;
         ST_O_M2:    state_in = ST_O_T;
         ST_O_T:     state_in = ST_D_START;
         ST_D_START: state_in = ST_D_WAIT;
         ST_D_WAIT: begin
            if (status.div_done) begin
               state_in = ST_O_OUT;
            end
         end
         ST_O_OUT:   state_in = ST_O_EMIT;
         ST_O_EMIT: begin
            if (status.out_taken) begin
               state_in = status.idx_last ? ST_LOAD : ST_O_RD;
            end
         end
         default:    state_in = ST_LOAD;
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_N2:    cmd.n2_en = 1'b1;
         ST_N3:    cmd.n3_en = 1'b1;
         ST_EPS: begin
            cmd.eps_en  = 1'b1;
            cmd.idx_clr = 1'b1;
         end
         ST_V_RD:  cmd.rd_en  = 1'b1;
         ST_V_NX:  cmd.nx_en  = 1'b1;
         ST_V_DEV: cmd.dev_en = 1'b1;
         ST_V_SQ:  cmd.sq_en  = 1'b1;
         ST_V_ACC: begin
            cmd.acc_en  = 1'b1;
            cmd.idx_clr = status.idx_last;
            cmd.idx_inc = ~status.idx_last;
         end
         ST_Q_START: cmd.q_start = ~status.w_zero;
         ST_R_START: cmd.r_start = 1'b1;
         ST_RSTD:    cmd.rstd_en = 1'b1;
         ST_O_RD:    cmd.rd_en   = 1'b1;
         ST_O_NX:    cmd.nx_en   = 1'b1;
         ST_O_DEV:   cmd.dev_en  = 1'b1;
         ST_O_M1:    cmd.m1_en   = 1'b1;
         ST_O_M2:    cmd.m2_en   = 1'b1;
         ST_O_T:     cmd.t_en    = 1'b1;
         ST_D_START: cmd.d_start = 1'b1;
         ST_O_OUT:   cmd.out_load = 1'b1;
         ST_O_EMIT: begin
            cmd.row_clr = status.out_taken & status.idx_last;
            cmd.idx_inc = status.out_taken & ~status.idx_last;
         end
         default: begin
            cmd       = '0;
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/layer_normalization.sv =====
// ----------------------------------------------------------------------------
// layer_normalization
// Fixed-point layer normalization of one row with per-element gain and offset.
// ----------------------------------------------------------------------------
// Items are taken one per cycle until the row holds row_length elements
// (0 counts as 1, above 64 as 64); the input then stalls until the whole row
// has been emitted, in order, with last_of_row on the final element. After
// the last item the block runs the mean-free variance pass and the root
// scale, with the 53-step shared divider and the 27-step square root; each
// output element then uses the same divider for the rounding divide by n and
// is held while rsp_stall is high. Configuration must be written through the
// register port only while no row is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module layer_normalization (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // input items
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [lnorm_pkg::DATA_W-1:0]   req_sample,
   input  wire logic signed [lnorm_pkg::DATA_W-1:0]   req_gain,
   input  wire logic signed [lnorm_pkg::DATA_W-1:0]   req_offset,
   // result items
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [lnorm_pkg::DATA_W-1:0]        rsp_normalized,
   output logic                                       rsp_last_of_row,
   // register port
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [lnorm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [lnorm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic      [lnorm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                       csr_pready
);
   import lnorm_pkg::*;

   logic [LEN_W-1:0] row_length_ff, row_length_in;
   logic [EPS_W-1:0] epsilon_ff, epsilon_in;
   logic [LEN_W-1:0] eff_len;
   logic             csr_wr;
   logic [0:0]       csr_index;
   cmd_type          cmd;
   status_type       status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];

   // Register writes
   always_comb begin
      row_length_in = row_length_ff;
      epsilon_in    = epsilon_ff;
      if (csr_wr) begin
         case (csr_index)
            REG_ROW_LENGTH: row_length_in = csr_pwdata[LEN_W-1:0];
            REG_EPSILON:    epsilon_in    = csr_pwdata[EPS_W-1:0];
            default:        row_length_in = row_length_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= LEN_W'(MAX_ROW);
         epsilon_ff    <= EPS_W'(1);
      end else begin
         row_length_ff <= row_length_in;
         epsilon_ff    <= epsilon_in;
      end
   end

   // Register reads
   always_comb begin
      case (csr_index)
         REG_ROW_LENGTH: csr_prdata = CSR_DATA_W'(row_length_ff);
         REG_EPSILON:    csr_prdata = CSR_DATA_W'(epsilon_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Clamp the row length to 1..MAX_ROW
   always_comb begin
      if (row_length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (row_length_ff > LEN_W'(MAX_ROW)) begin
         eff_len = LEN_W'(MAX_ROW);
      end else begin
         eff_len = row_length_ff;
      end
   end

   lnorm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lnorm_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .eff_len         (eff_len),
      .epsilon         (epsilon_ff),
      .req_sample      (req_sample),
      .req_gain        (req_gain),
      .req_offset      (req_offset),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_normalized  (rsp_normalized),
      .rsp_last_of_row (rsp_last_of_row)
   );

endmodule

`default_nettype wire

// ===== tb/layer_normalization_checker.sv =====
// ----------------------------------------------------------------------------
// layer_normalization_checker
// Watches the item, result and register channels of the layer normalization
// block, predicts every normalized row from the accepted items and compares
// each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module layer_normalization_checker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   input  wire logic                                  req_stall,
   input  wire logic signed [lnorm_pkg::DATA_W-1:0]   req_sample,
   input  wire logic signed [lnorm_pkg::DATA_W-1:0]   req_gain,
   input  wire logic signed [lnorm_pkg::DATA_W-1:0]   req_offset,
   input  wire logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   input  wire logic signed [lnorm_pkg::DATA_W-1:0]   rsp_normalized,
   input  wire logic                                  rsp_last_of_row,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [lnorm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [lnorm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   input  wire logic                                  csr_pready,
   output int                                         mismatches,
   output int                                         pending,
   output int                                         results_checked,
   output int                                         rows_seen
);
   import lnorm_pkg::*;

   typedef struct {
      logic signed [DATA_W-1:0] normalized;
      logic                     last_of_row;
   } norm_result_type;

   localparam logic [CSR_ADDR_W-1:0] ADDR_ROW_LENGTH = CSR_ADDR_W'(4 * REG_ROW_LENGTH);
   localparam logic [CSR_ADDR_W-1:0] ADDR_EPSILON    = CSR_ADDR_W'(4 * REG_EPSILON);

   norm_result_type          expected_norms[$];
   logic [LEN_W-1:0]         cfg_row_length;
   logic [EPS_W-1:0]         cfg_epsilon;
   logic signed [DATA_W-1:0] row_samples[MAX_ROW];
   logic signed [DATA_W-1:0] row_gains[MAX_ROW];
   logic signed [DATA_W-1:0] row_offsets[MAX_ROW];
   int                       row_fill;
   longint                   row_sum;

   // integer square root by the digit-by-digit method
   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bit_w;
      root  = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= root + bit_w) begin
            v    = v - (root + bit_w);
            root = (root >> 1) + bit_w;
         end else begin
            root = root >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return root;
   endfunction

   // normalize the buffered row and queue its results
   task automatic predict_row();
      longint unsigned n3, var_sum, w, rstd, dm, gm, dv, mag;
      longint          d, y;
      logic            neg;
      norm_result_type r;
      n3      = longint'(row_fill) * row_fill * row_fill;
      var_sum = 0;
      for (int j = 0; j < row_fill; j++) begin
         d       = longint'(row_fill) * row_samples[j] - row_sum;
         dm      = (d < 0) ? -d : d;
         var_sum = var_sum + dm * dm;
      end
      w = var_sum + longint'(cfg_epsilon) * n3;
      if (w == 0) rstd = 0;
      else rstd = (int_sqrt((n3 << 34) / w) + 1) >> 1;
      dv = longint'(row_fill) << 28;
      for (int j = 0; j < row_fill; j++) begin
         d   = longint'(row_fill) * row_samples[j] - row_sum;
         neg = (d < 0) != (row_gains[j] < 0);
         dm  = (d < 0) ? -d : d;
         gm  = (row_gains[j] < 0) ? -longint'(row_gains[j]) : longint'(row_gains[j]);
         mag = (dm * rstd * gm + (dv >> 1)) / dv;
         y   = neg ? -longint'(mag) : longint'(mag);
         y   = y + row_offsets[j];
         if (y > OUT_MAX) y = OUT_MAX;
         if (y < OUT_MIN) y = OUT_MIN;
         r.normalized  = y[DATA_W-1:0];
         r.last_of_row = (j + 1 == row_fill);
         expected_norms.push_back(r);
      end
      rows_seen++;
      row_fill = 0;
      row_sum  = 0;
   endtask

   // report one mismatch, the first ten in full
   task automatic report(string what, longint exp_v, longint act_v);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %0d actual %0d", what, exp_v, act_v);
   endtask

   always @(posedge clock) begin
      int              eff_len;
      norm_result_type e;
      if (reset) begin
         cfg_row_length  <= 7'd64;
         cfg_epsilon     <= 16'd1;
         row_fill        = 0;
         row_sum         = 0;
         expected_norms.delete();
         mismatches      = 0;
         results_checked = 0;
         rows_seen       = 0;
      end else begin
         // track register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == ADDR_ROW_LENGTH) cfg_row_length <= csr_pwdata[LEN_W-1:0];
            if (csr_paddr == ADDR_EPSILON)    cfg_epsilon    <= csr_pwdata[EPS_W-1:0];
         end
         // buffer accepted items and finish rows
         if (req_valid && !req_stall) begin
            if (row_fill >= MAX_ROW) row_fill = 0;
            row_samples[row_fill] = req_sample;
            row_gains[row_fill]   = req_gain;
            row_offsets[row_fill] = req_offset;
            row_sum  = row_sum + req_sample;
            row_fill = row_fill + 1;
            eff_len  = int'(cfg_row_length);
            if (eff_len < 1) eff_len = 1;
            if (eff_len > MAX_ROW) eff_len = MAX_ROW;
            if (row_fill >= eff_len) predict_row();
         end
         // compare accepted results
         if (rsp_valid && !rsp_stall) begin
            if (expected_norms.size() == 0) begin
               report("unexpected result, normalized", 0, rsp_normalized);
            end else begin
               e = expected_norms.pop_front();
               results_checked++;
               if (rsp_normalized !== e.normalized)
                  report("normalized", e.normalized, rsp_normalized);
               if (rsp_last_of_row !== e.last_of_row)
                  report("last_of_row", e.last_of_row, rsp_last_of_row);
            end
         end
      end
      pending = expected_norms.size();
   end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives rows of items and register settings into the layer normalization
// block with random idling on both channels; a checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import lnorm_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] ADDR_ROW_LENGTH = CSR_ADDR_W'(4 * REG_ROW_LENGTH);
   localparam logic [CSR_ADDR_W-1:0] ADDR_EPSILON    = CSR_ADDR_W'(4 * REG_EPSILON);
   localparam int ITEM_TARGET = 500;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_sample = '0;
   logic signed [DATA_W-1:0] req_gain = '0;
   logic signed [DATA_W-1:0] req_offset = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_normalized;
   logic                     rsp_last_of_row;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]    csr_paddr = '0;
   logic [CSR_DATA_W-1:0]    csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]    csr_prdata;
   logic                     csr_pready;

   int   mismatches, pending, results_checked, rows_seen;
   int   items_sent = 0;
   bit   no_idle = 1'b0;
   bit   long_hold = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   layer_normalization dut (.*);

   layer_normalization_checker checker_i (.*);

   // write one register: setup phase, then access phase
   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // offer one item after a random gap and hold it until accepted
   task automatic send_item(logic signed [DATA_W-1:0] s, logic signed [DATA_W-1:0] g,
                            logic signed [DATA_W-1:0] o);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      req_gain   <= g;
      req_offset <= o;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // offer one item with all fields random
   task automatic send_random();
      send_item(DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
   endtask

   // wait until every predicted result has arrived, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (100) @(posedge clock);
   endtask

   // random sample in one of a few styles: full range, narrow, or constant
   function automatic logic signed [DATA_W-1:0] pick_sample(int style, int base);
      case (style)
         0: return DATA_W'($urandom);
         1: return DATA_W'(base + $urandom_range(0, 64) - 32);
         default: return DATA_W'(base);
      endcase
   endfunction

   // receiver: random stall per result, one long hold-off on request
   initial begin
      int w;
      @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (600) @(posedge clock);
            long_hold = 1'b0;
         end
         w = no_idle ? 0 : $urandom_range(0, 7);
         if (w > 0) begin
            rsp_stall <= 1'b1;
            repeat (w) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid && !long_hold);
      end
   end

   // stimulus
   initial begin
      int len, style, base, rows;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-element rows with zero epsilon: zero variance, output is offset
      csr_write(ADDR_ROW_LENGTH, 1);
      csr_write(ADDR_EPSILON, 0);
      send_item(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_item(16'sh8000, 16'sh8000, 16'sh8000);
      drain();
      // zero length counts as one
      csr_write(ADDR_ROW_LENGTH, 0);
      send_item(16'sh1234, 16'sh8000, 16'sh0000);
      drain();
      // pairs: extremes toward saturation, then a constant pair
      csr_write(ADDR_ROW_LENGTH, 2);
      send_item(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_item(16'sh8000, 16'sh8000, 16'sh8000);
      send_item(16'sh7fff, 16'sh8000, 16'sh0000);
      send_item(16'sh8000, 16'sh7fff, 16'sh0000);
      send_item(16'sh0100, 16'sh1000, 16'sh0000);
      send_item(16'sh0100, 16'sh1000, 16'sh0005);
      drain();
      // largest epsilon
      csr_write(ADDR_ROW_LENGTH, 3);
      csr_write(ADDR_EPSILON, 32'h0000_ffff);
      send_item(16'sh0000, 16'sh7fff, 16'sh0000);
      send_item(16'sh7fff, 16'sh7fff, 16'sh0000);
      send_item(16'sh8000, 16'sh8000, 16'sh7fff);
      drain();
      // lower the length under a partly filled row
      csr_write(ADDR_ROW_LENGTH, 8);
      csr_write(ADDR_EPSILON, 1);
      for (int i = 0; i < 5; i++) send_random();
      drain();
      csr_write(ADDR_ROW_LENGTH, 3);
      send_random();
      drain();

      // hold results back while items keep coming so the input stalls
      csr_write(ADDR_ROW_LENGTH, 4);
      long_hold = 1'b1;
      for (int i = 0; i < 40; i++) send_random();
      drain();

      // random phases of whole rows with random settings
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0:       len = 64;
            1:       len = 127;
            2:       len = $urandom_range(9, 32);
            default: len = $urandom_range(1, 8);
         endcase
         csr_write(ADDR_ROW_LENGTH, len);
         case ($urandom_range(0, 3))
            0: csr_write(ADDR_EPSILON, 0);
            1: csr_write(ADDR_EPSILON, 32'h0000_ffff);
            default: csr_write(ADDR_EPSILON, $urandom_range(0, 255));
         endcase
         if (len > 64) len = 64;
         no_idle = ($urandom_range(0, 3) == 0);
         rows = (len > 16) ? 1 : $urandom_range(1, 4);
         for (int r = 0; r < rows; r++) begin
            style = $urandom_range(0, 3);
            base  = $urandom_range(0, 65535) - 32768;
            for (int i = 0; i < len; i++)
               send_item(pick_sample(style, base), DATA_W'($urandom), DATA_W'($urandom));
         end
         // now and then leave a partial row for the next setting
         if ($urandom_range(0, 7) == 0)
            for (int i = 0; i < 3; i++) send_random();
         no_idle = 1'b0;
         drain();
      end
      // close out any partial row
      csr_write(ADDR_ROW_LENGTH, 1);
      send_random();
      drain();

      $display("covered %0d items in %0d rows, %0d results compared", items_sent, rows_seen,
               results_checked);
      $display("row lengths 0 to 127, epsilon 0 to 65535, long result hold-off included");
      if (mismatches == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // end the run if it hangs
   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
